[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MPSVD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain property checked at every clock edge outside reset.
`define MPSVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

[src/mpsvd_pkg.sv]
// ----------------------------------------------------------------------------
// mpsvd_pkg
// Types, codes and helpers of the program stream video demultiplexer.
// ----------------------------------------------------------------------------
package mpsvd_pkg;

    localparam int PAYLOAD_W         = 8;
    localparam int FRAME_BYTES_W     = 19;
    localparam int PTS_W             = 33;
    localparam int MS_W              = 27;
    localparam int FRAME_COUNT_BITS_DEF = 19;

    localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_MAX = '1;

    localparam logic [7:0]  SID_PACK       = 8'hBA;
    localparam logic [7:0]  SID_SYSTEM     = 8'hBB;
    localparam logic [7:0]  VIDEO_ID_RESET = 8'hE0;
    localparam logic [23:0] START_PREFIX   = 24'h000001;
    localparam logic [23:0] WINDOW_IDLE    = 24'hFFFFFF;
    localparam logic [15:0] PACK_FIXED_LEN = 16'd9;
    localparam logic [1:0]  PES_MARKER     = 2'b10;
    localparam logic [15:0] PTS_BYTES      = 16'd5;
    localparam int          DIV_BASE       = 90;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_PACK_FIXED,
        PH_PACK_STUFF,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_PES_LEN_HI,
        PH_PES_LEN_LO,
        PH_PES_MARK,
        PH_PES_FLAGS,
        PH_PES_HLEN,
        PH_PES_HDR,
        PH_PES_DATA,
        PH_PES_DROP
    } t_phase;

    typedef enum logic [2:0] {
        PTS_TOP    = 3'd0,
        PTS_MID_HI = 3'd1,
        PTS_MID_LO = 3'd2,
        PTS_LOW_HI = 3'd3,
        PTS_LOW_LO = 3'd4
    } t_pts_step;

    typedef struct packed {
        logic       en;
        t_pts_step  step;
        logic       commit;
        logic [7:0] data;
    } t_pts_ctl;

    typedef struct packed {
        logic [MS_W-1:0] q;
        logic [6:0]      r;
    } t_div;

    typedef struct packed {
        t_kind                    kind;
        logic [PAYLOAD_W-1:0]     payload_byte;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
        logic [PTS_W-1:0]         pts_ticks;
        logic [MS_W-1:0]          stamp_ms;
        logic                     key_frame;
    } t_result;

    // Shift the low nbits of v, MSB first, into a running quotient/remainder by 90.
    function automatic t_div div90_push(input t_div d, input logic [7:0] v,
                                        input logic [3:0] nbits);
        t_div       res;
        logic [7:0] t;
        res = d;
        for (int i = 7; i >= 0; i--) begin
            if (4'(i) < nbits) begin
                t = {res.r, v[3'(i)]};
                if (t >= 8'(DIV_BASE)) begin
                    res.r = 7'(t - 8'(DIV_BASE));
                    res.q = {res.q[MS_W-2:0], 1'b1};
                end else begin
                    res.r = t[6:0];
                    res.q = {res.q[MS_W-2:0], 1'b0};
                end
            end
        end
        return res;
    endfunction

endpackage

[src/mpsvd_ifs.sv]
// ----------------------------------------------------------------------------
// mpsvd interfaces
// Valid/ready channels for stream bytes, configuration and results.
// ----------------------------------------------------------------------------
interface mpsvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mpsvd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] video_stream_id;
    modport source (output valid, output video_stream_id, input ready);
    modport sink   (input valid, input video_stream_id, output ready);
endinterface

interface mpsvd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [18:0] frame_bytes;
    logic [32:0] pts_ticks;
    logic [26:0] stamp_ms;
    logic        key_frame;
    modport source (output valid, output kind, output payload_byte, output frame_bytes,
                    output pts_ticks, output stamp_ms, output key_frame, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_bytes,
                    input pts_ticks, input stamp_ms, input key_frame, output ready);
endinterface

[src/mpsvd_pts_unit.sv]
// ----------------------------------------------------------------------------
// mpsvd_pts_unit
// Assembles the 33-bit PTS and its quotient by 90, one header byte per step.
// ----------------------------------------------------------------------------
module mpsvd_pts_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mpsvd_pkg::t_pts_ctl             i_ctl,
    output logic [mpsvd_pkg::PTS_W-1:0]     o_frame_pts,
    output logic [mpsvd_pkg::MS_W-1:0]      o_frame_ms
);

    logic [mpsvd_pkg::PTS_W-1:0] r_build, n_build;
    mpsvd_pkg::t_div             r_div, n_div;
    logic [mpsvd_pkg::PTS_W-1:0] r_frame_pts;
    logic [mpsvd_pkg::MS_W-1:0]  r_frame_ms;

    always_comb begin
        n_build = r_build;
        n_div   = r_div;
        unique case (i_ctl.step)
            mpsvd_pkg::PTS_TOP: begin
                n_build = {30'd0, i_ctl.data[3:1]};
                n_div   = mpsvd_pkg::div90_push('0, {5'd0, i_ctl.data[3:1]}, 4'd3);
            end
            mpsvd_pkg::PTS_MID_HI, mpsvd_pkg::PTS_LOW_HI: begin
                n_build = {r_build[24:0], i_ctl.data};
                n_div   = mpsvd_pkg::div90_push(r_div, i_ctl.data, 4'd8);
            end
            mpsvd_pkg::PTS_MID_LO, mpsvd_pkg::PTS_LOW_LO: begin
                n_build = {r_build[25:0], i_ctl.data[7:1]};
                n_div   = mpsvd_pkg::div90_push(r_div, {1'b0, i_ctl.data[7:1]}, 4'd7);
            end
            default: begin
                n_build = r_build;
                n_div   = r_div;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build     <= '0;
            r_div       <= '0;
            r_frame_pts <= '0;
            r_frame_ms  <= '0;
        end else if (i_ctl.en) begin
            r_build <= n_build;
            r_div   <= n_div;
            if (i_ctl.step == mpsvd_pkg::PTS_LOW_LO && i_ctl.commit) begin
                r_frame_pts <= n_build;
                r_frame_ms  <= n_div.q;
            end
        end
    end

    assign o_frame_pts = r_frame_pts;
    assign o_frame_ms  = r_frame_ms;

endmodule

[src/mpsvd_parser.sv]
// ----------------------------------------------------------------------------
// mpsvd_parser
// Start code hunt, header skipping and PES parsing, one byte per transaction.
// ----------------------------------------------------------------------------
module mpsvd_parser #(
    parameter int FRAME_COUNT_BITS = mpsvd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [7:0]                      i_byte,
    input  logic [7:0]                      i_video_id,
    input  logic [mpsvd_pkg::PTS_W-1:0]     i_frame_pts,
    input  logic [mpsvd_pkg::MS_W-1:0]      i_frame_ms,
    output mpsvd_pkg::t_pts_ctl             o_pts_ctl,
    output logic                            o_push,
    output mpsvd_pkg::t_result              o_result
);

    localparam int CW = (FRAME_COUNT_BITS > mpsvd_pkg::FRAME_BYTES_W) ?
                        FRAME_COUNT_BITS : mpsvd_pkg::FRAME_BYTES_W;

    mpsvd_pkg::t_phase           r_phase, n_phase;
    logic [23:0]                 r_window, n_window;
    logic [15:0]                 r_skip, n_skip;
    logic [15:0]                 r_payload_left, n_payload_left;
    logic [7:0]                  r_header_left, n_header_left;
    logic [1:0]                  r_ts_flags, n_ts_flags;
    logic                        r_key_seen, n_key_seen;
    logic [FRAME_COUNT_BITS-1:0] r_frame_count, n_frame_count;
    logic                        r_is_video, n_is_video;

    logic        prefix_hit;
    logic        skip_last;
    logic        payload_last;
    logic        header_last;
    logic [15:0] skip_dec;
    logic [CW-1:0] count_ext;
    logic [mpsvd_pkg::FRAME_BYTES_W-1:0] frame_bytes;
    logic        push;
    mpsvd_pkg::t_pts_ctl pts_ctl;

    assign prefix_hit   = (r_window == mpsvd_pkg::START_PREFIX);
    assign skip_last    = (r_skip <= 16'd1);
    assign payload_last = (r_payload_left <= 16'd1);
    assign header_last  = (r_header_left <= 8'd1);
    assign skip_dec     = (r_skip != 16'd0) ? r_skip - 16'd1 : 16'd0;
    assign count_ext    = CW'(r_frame_count);
    assign frame_bytes  = (count_ext > CW'(mpsvd_pkg::FRAME_BYTES_MAX)) ?
                          mpsvd_pkg::FRAME_BYTES_MAX : count_ext[mpsvd_pkg::FRAME_BYTES_W-1:0];

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            mpsvd_pkg::PH_HUNT: begin
                if (prefix_hit) begin
                    priority if (i_byte == mpsvd_pkg::SID_PACK) begin
                        n_phase = mpsvd_pkg::PH_PACK_FIXED;
                    end else if (i_byte == i_video_id) begin
                        n_phase = mpsvd_pkg::PH_PES_LEN_HI;
                    end else begin
                        n_phase = mpsvd_pkg::PH_LEN_HI;
                    end
                end
            end
            mpsvd_pkg::PH_PACK_FIXED: begin
                if (skip_last) n_phase = mpsvd_pkg::PH_PACK_STUFF;
            end
            mpsvd_pkg::PH_PACK_STUFF: begin
                n_phase = (i_byte[2:0] != 3'd0) ? mpsvd_pkg::PH_SKIP : mpsvd_pkg::PH_HUNT;
            end
            mpsvd_pkg::PH_LEN_HI: n_phase = mpsvd_pkg::PH_LEN_LO;
            mpsvd_pkg::PH_LEN_LO: begin
                n_phase = (r_skip[15:8] != 8'd0 || i_byte != 8'd0) ?
                          mpsvd_pkg::PH_SKIP : mpsvd_pkg::PH_HUNT;
            end
            mpsvd_pkg::PH_SKIP: begin
                if (skip_last) n_phase = mpsvd_pkg::PH_HUNT;
            end
            mpsvd_pkg::PH_PES_LEN_HI: n_phase = mpsvd_pkg::PH_PES_LEN_LO;
            mpsvd_pkg::PH_PES_LEN_LO: begin
                n_phase = (r_payload_left[15:8] != 8'd0 || i_byte != 8'd0) ?
                          mpsvd_pkg::PH_PES_MARK : mpsvd_pkg::PH_HUNT;
            end
            mpsvd_pkg::PH_PES_MARK, mpsvd_pkg::PH_PES_FLAGS, mpsvd_pkg::PH_PES_HLEN,
            mpsvd_pkg::PH_PES_HDR, mpsvd_pkg::PH_PES_DATA, mpsvd_pkg::PH_PES_DROP: begin
                priority if (payload_last) begin
                    n_phase = mpsvd_pkg::PH_HUNT;
                end else if (r_phase == mpsvd_pkg::PH_PES_MARK) begin
                    n_phase = (i_byte[7:6] == mpsvd_pkg::PES_MARKER) ?
                              mpsvd_pkg::PH_PES_FLAGS : mpsvd_pkg::PH_PES_DROP;
                end else if (r_phase == mpsvd_pkg::PH_PES_FLAGS) begin
                    n_phase = mpsvd_pkg::PH_PES_HLEN;
                end else if (r_phase == mpsvd_pkg::PH_PES_HLEN) begin
                    n_phase = (i_byte != 8'd0) ? mpsvd_pkg::PH_PES_HDR : mpsvd_pkg::PH_PES_DATA;
                end else if (r_phase == mpsvd_pkg::PH_PES_HDR) begin
                    n_phase = header_last ? mpsvd_pkg::PH_PES_DATA : mpsvd_pkg::PH_PES_HDR;
                end else begin
                    n_phase = r_phase;
                end
            end
            default: n_phase = mpsvd_pkg::PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        n_window       = (r_phase == mpsvd_pkg::PH_HUNT && !prefix_hit) ?
                         {r_window[15:0], i_byte} : mpsvd_pkg::WINDOW_IDLE;
        n_skip         = r_skip;
        n_payload_left = r_payload_left;
        n_header_left  = r_header_left;
        n_ts_flags     = r_ts_flags;
        n_key_seen     = r_key_seen;
        n_frame_count  = r_frame_count;
        n_is_video     = r_is_video;
        push           = 1'b0;
        o_result       = '0;
        pts_ctl        = '0;
        pts_ctl.data   = i_byte;
        pts_ctl.commit = r_is_video;
        unique case (r_phase)
            mpsvd_pkg::PH_HUNT: begin
                if (prefix_hit) begin
                    priority if (i_byte == mpsvd_pkg::SID_PACK) begin
                        if (r_frame_count != '0) begin
                            push                 = 1'b1;
                            o_result.kind        = mpsvd_pkg::KIND_FRAME_END;
                            o_result.frame_bytes = frame_bytes;
                            o_result.pts_ticks   = i_frame_pts;
                            o_result.stamp_ms    = i_frame_ms;
                            o_result.key_frame   = r_key_seen;
                            n_frame_count        = '0;
                            n_key_seen           = 1'b0;
                        end
                        n_is_video = 1'b0;
                        n_skip     = mpsvd_pkg::PACK_FIXED_LEN;
                    end else if (i_byte == i_video_id) begin
                        n_is_video = 1'b1;
                    end else begin
                        n_is_video = 1'b0;
                        if (i_byte == mpsvd_pkg::SID_SYSTEM) n_key_seen = 1'b1;
                    end
                end
            end
            mpsvd_pkg::PH_PACK_FIXED, mpsvd_pkg::PH_SKIP: n_skip = skip_dec;
            mpsvd_pkg::PH_PACK_STUFF: n_skip = {13'd0, i_byte[2:0]};
            mpsvd_pkg::PH_LEN_HI:     n_skip = {i_byte, 8'd0};
            mpsvd_pkg::PH_LEN_LO:     n_skip = {r_skip[15:8], i_byte};
            mpsvd_pkg::PH_PES_LEN_HI: n_payload_left = {i_byte, 8'd0};
            mpsvd_pkg::PH_PES_LEN_LO: n_payload_left = {r_payload_left[15:8], i_byte};
            mpsvd_pkg::PH_PES_MARK, mpsvd_pkg::PH_PES_FLAGS, mpsvd_pkg::PH_PES_HLEN,
            mpsvd_pkg::PH_PES_HDR, mpsvd_pkg::PH_PES_DATA, mpsvd_pkg::PH_PES_DROP: begin
                n_payload_left = (r_payload_left != 16'd0) ? r_payload_left - 16'd1 : 16'd0;
                if (r_phase == mpsvd_pkg::PH_PES_FLAGS) begin
                    n_ts_flags = i_byte[7:6];
                end
                if (r_phase == mpsvd_pkg::PH_PES_HLEN) begin
                    n_header_left = i_byte;
                    n_skip        = 16'd0;
                end
                if (r_phase == mpsvd_pkg::PH_PES_HDR) begin
                    if (r_ts_flags[1] && r_skip < mpsvd_pkg::PTS_BYTES) begin
                        pts_ctl.en   = 1'b1;
                        pts_ctl.step = mpsvd_pkg::t_pts_step'(r_skip[2:0]);
                    end
                    if (r_skip != 16'hFFFF) n_skip = r_skip + 16'd1;
                    n_header_left = (r_header_left != 8'd0) ? r_header_left - 8'd1 : 8'd0;
                end
                if (r_phase == mpsvd_pkg::PH_PES_DATA && r_is_video) begin
                    push                  = 1'b1;
                    o_result.kind         = mpsvd_pkg::KIND_PAYLOAD;
                    o_result.payload_byte = i_byte;
                    if (r_frame_count != '1) begin
                        n_frame_count = r_frame_count + FRAME_COUNT_BITS'(1);
                    end
                end
            end
            default: n_skip = r_skip;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= mpsvd_pkg::PH_HUNT;
            r_window       <= mpsvd_pkg::WINDOW_IDLE;
            r_skip         <= '0;
            r_payload_left <= '0;
            r_header_left  <= '0;
            r_ts_flags     <= '0;
            r_key_seen     <= 1'b0;
            r_frame_count  <= '0;
            r_is_video     <= 1'b0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_window       <= n_window;
            r_skip         <= n_skip;
            r_payload_left <= n_payload_left;
            r_header_left  <= n_header_left;
            r_ts_flags     <= n_ts_flags;
            r_key_seen     <= n_key_seen;
            r_frame_count  <= n_frame_count;
            r_is_video     <= n_is_video;
        end
    end

    always_comb begin
        o_pts_ctl    = pts_ctl;
        o_pts_ctl.en = pts_ctl.en && i_accept;
    end

    assign o_push = push && i_accept;

endmodule

[src/mpsvd_out_buf.sv]
// ----------------------------------------------------------------------------
// mpsvd_out_buf
// Two-entry result register: output stage plus skid stage.
// ----------------------------------------------------------------------------
module mpsvd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mpsvd_pkg::t_result i_data,
    output logic               o_space,
    output logic               o_valid,
    output mpsvd_pkg::t_result o_data,
    input  logic               i_ready
);

    logic               r_main_valid;
    logic               r_skid_valid;
    mpsvd_pkg::t_result r_main;
    mpsvd_pkg::t_result r_skid;
    logic               pop;

    assign pop = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push && r_main_valid && !pop) begin
            r_skid_valid <= 1'b1;
        end else if (i_push) begin
            r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload: advance skid into main on pop, else load new transaction
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) r_main <= r_skid;
        end else if (i_push && r_main_valid && !pop) begin
            r_skid <= i_data;
        end else if (i_push) begin
            r_main <= i_data;
        end
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

[src/mpeg_ps_video_demux_unit.sv]
// ----------------------------------------------------------------------------
// mpeg_ps_video_demux_unit
// MPEG-2 program stream video demultiplexer, one stream byte per transaction.
// ----------------------------------------------------------------------------
// Takes one program stream byte per clock while the output buffer has room,
// and forwards the payload of the configured video PES stream, with a
// frame-end result (byte count, PTS, PTS in milliseconds, key flag) at each
// pack header that closes a non-empty frame. Each byte is parsed in the cycle
// it is accepted and its result, if any, is registered in the output buffer,
// so throughput is one byte per cycle while the result side keeps up. The
// output has a two-entry buffer; byte ready drops only when both entries hold
// results. The PTS quotient by 90 is built bit-serially as the PTS bytes
// arrive, so stamp_ms needs no divider after the frame ends. The configuration
// channel is always ready; write it only while the block is idle.
`include "assert_macros.svh"

module mpeg_ps_video_demux_unit #(
    parameter int FRAME_COUNT_BITS = mpsvd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mpsvd_byte_if.sink             i_byte,
    mpsvd_cfg_if.sink              i_cfg,
    mpsvd_result_if.source         o_result
);

    logic [7:0]                   r_video_id;
    logic                         accept;
    logic                         buf_space;
    logic                         push;
    mpsvd_pkg::t_result           result;
    mpsvd_pkg::t_result           out_data;
    mpsvd_pkg::t_pts_ctl          pts_ctl;
    logic [mpsvd_pkg::PTS_W-1:0]  frame_pts;
    logic [mpsvd_pkg::MS_W-1:0]   frame_ms;
    logic [33:0]                  ms_x90;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = buf_space;
    assign accept       = i_byte.valid && buf_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_id <= mpsvd_pkg::VIDEO_ID_RESET;
        end else if (i_cfg.valid) begin
            r_video_id <= i_cfg.video_stream_id;
        end
    end

    mpsvd_parser #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_byte.stream_byte),
        .i_video_id  (r_video_id),
        .i_frame_pts (frame_pts),
        .i_frame_ms  (frame_ms),
        .o_pts_ctl   (pts_ctl),
        .o_push      (push),
        .o_result    (result)
    );

    mpsvd_pts_unit u_pts (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pts_ctl),
        .o_frame_pts (frame_pts),
        .o_frame_ms  (frame_ms)
    );

    mpsvd_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_space (buf_space),
        .o_valid (o_result.valid),
        .o_data  (out_data),
        .i_ready (o_result.ready)
    );

    assign o_result.kind         = out_data.kind;
    assign o_result.payload_byte = out_data.payload_byte;
    assign o_result.frame_bytes  = out_data.frame_bytes;
    assign o_result.pts_ticks    = out_data.pts_ticks;
    assign o_result.stamp_ms     = out_data.stamp_ms;
    assign o_result.key_frame    = out_data.key_frame;

    assign ms_x90 = 34'(o_result.stamp_ms) * 34'd90;

    `MPSVD_ASSERT_IMPL(a_ms_matches_pts,
        (o_result.valid && o_result.kind == 1'(mpsvd_pkg::KIND_FRAME_END)),
        (ms_x90 <= 34'(o_result.pts_ticks) && 34'(o_result.pts_ticks) - ms_x90 < 34'd90),
        "stamp_ms is not pts_ticks / 90")
    `MPSVD_ASSERT_IMPL(a_frame_not_empty,
        (o_result.valid && o_result.kind == 1'(mpsvd_pkg::KIND_FRAME_END)),
        (o_result.frame_bytes != '0),
        "frame-end transaction with zero frame bytes")
    `MPSVD_ASSERT_IMPL(a_payload_fields_clear,
        (o_result.valid && o_result.kind == 1'(mpsvd_pkg::KIND_PAYLOAD)),
        (o_result.frame_bytes == '0 && o_result.pts_ticks == '0 &&
         o_result.stamp_ms == '0 && o_result.key_frame == 1'b0),
        "payload transaction carries frame-end fields")

endmodule

[tb/sv/mpsvd_demux_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpsvd_demux_checker
// Watches the stream, configuration and result channels of the program stream
// video demultiplexer. Every accepted stream byte runs through a byte-serial
// model of the parser, and the payload or frame-end result that it yields is
// queued. Each accepted result is compared field by field with the oldest
// queued one. The failure count and the number of results still outstanding
// go back to the testbench top.
// ----------------------------------------------------------------------------
module mpsvd_demux_checker #(
    parameter int FRAME_COUNT_BITS = mpsvd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mpsvd_byte_if   i_byte,
    mpsvd_cfg_if    i_cfg,
    mpsvd_result_if i_result,
    output int      o_fail_count,
    output int      o_pending
);
    import mpsvd_pkg::*;

    localparam int unsigned BYTE_COUNT_MAX = (1 << FRAME_COUNT_BITS) - 1;

    logic [7:0]       video_id;
    logic [23:0]      start_window;
    t_phase           parse_at;
    logic [15:0]      skip_left;
    logic [15:0]      pes_left;
    logic [7:0]       hdr_left;
    logic [1:0]       ts_flags;
    logic [PTS_W-1:0] pts_acc;
    logic [PTS_W-1:0] frame_stamp;
    logic             key_mark;
    int unsigned      payload_tally;
    logic             in_video;

    t_result demux_out_q[$];
    int      errs = 0;

    function automatic void restart_hunt();
        parse_at     = PH_HUNT;
        start_window = WINDOW_IDLE;
    endfunction

    task automatic parse_stream_byte(input logic [7:0] b);
        t_result out_r;
        bit      emit;
        emit  = 1'b0;
        out_r = '0;
        case (parse_at)
            PH_HUNT: begin
                if (start_window == START_PREFIX) begin
                    start_window = WINDOW_IDLE;
                    if (b == SID_PACK) begin
                        if (payload_tally != 0) begin
                            out_r.kind        = KIND_FRAME_END;
                            out_r.frame_bytes = (payload_tally > FRAME_BYTES_MAX) ?
                                                FRAME_BYTES_MAX :
                                                payload_tally[FRAME_BYTES_W-1:0];
                            out_r.pts_ticks   = frame_stamp;
                            out_r.stamp_ms    = MS_W'(frame_stamp / DIV_BASE);
                            out_r.key_frame   = key_mark;
                            emit          = 1'b1;
                            payload_tally = 0;
                            key_mark      = 1'b0;
                        end
                        in_video  = 1'b0;
                        skip_left = PACK_FIXED_LEN;
                        parse_at  = PH_PACK_FIXED;
                    end else if (b == video_id) begin
                        in_video = 1'b1;
                        parse_at = PH_PES_LEN_HI;
                    end else begin
                        in_video = 1'b0;
                        if (b == SID_SYSTEM) key_mark = 1'b1;
                        parse_at = PH_LEN_HI;
                    end
                end else begin
                    start_window = {start_window[15:0], b};
                end
            end
            PH_PACK_FIXED: begin
                skip_left = (skip_left != 0) ? skip_left - 16'd1 : 16'd0;
                if (skip_left == 0) parse_at = PH_PACK_STUFF;
            end
            PH_PACK_STUFF: begin
                skip_left = {13'd0, b[2:0]};
                if (skip_left != 0) parse_at = PH_SKIP;
                else restart_hunt();
            end
            PH_LEN_HI: begin
                skip_left = {b, 8'h00};
                parse_at  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                skip_left[7:0] = b;
                if (skip_left != 0) parse_at = PH_SKIP;
                else restart_hunt();
            end
            PH_SKIP: begin
                skip_left = (skip_left != 0) ? skip_left - 16'd1 : 16'd0;
                if (skip_left == 0) restart_hunt();
            end
            PH_PES_LEN_HI: begin
                pes_left = {b, 8'h00};
                parse_at = PH_PES_LEN_LO;
            end
            PH_PES_LEN_LO: begin
                pes_left[7:0] = b;
                if (pes_left != 0) parse_at = PH_PES_MARK;
                else restart_hunt();
            end
            default: begin
                case (parse_at)
                    PH_PES_MARK: begin
                        parse_at = (b[7:6] == PES_MARKER) ? PH_PES_FLAGS : PH_PES_DROP;
                    end
                    PH_PES_FLAGS: begin
                        ts_flags = b[7:6];
                        parse_at = PH_PES_HLEN;
                    end
                    PH_PES_HLEN: begin
                        hdr_left  = b;
                        skip_left = 16'd0;
                        parse_at  = (b != 0) ? PH_PES_HDR : PH_PES_DATA;
                    end
                    PH_PES_HDR: begin
                        if (ts_flags[1] && skip_left < PTS_BYTES) begin
                            case (t_pts_step'(skip_left[2:0]))
                                PTS_TOP:    pts_acc = PTS_W'(b[3:1]);
                                PTS_MID_HI: pts_acc = {pts_acc[24:0], b};
                                PTS_MID_LO: pts_acc = {pts_acc[25:0], b[7:1]};
                                PTS_LOW_HI: pts_acc = {pts_acc[24:0], b};
                                default: begin
                                    pts_acc = {pts_acc[25:0], b[7:1]};
                                    if (in_video) frame_stamp = pts_acc;
                                end
                            endcase
                        end
                        if (skip_left != 16'hFFFF) skip_left = skip_left + 16'd1;
                        hdr_left = (hdr_left != 0) ? hdr_left - 8'd1 : 8'd0;
                        if (hdr_left == 0) parse_at = PH_PES_DATA;
                    end
                    PH_PES_DATA: begin
                        if (in_video) begin
                            out_r.kind         = KIND_PAYLOAD;
                            out_r.payload_byte = b;
                            emit = 1'b1;
                            if (payload_tally < BYTE_COUNT_MAX) payload_tally++;
                        end
                    end
                    default: ;
                endcase
                pes_left = (pes_left != 0) ? pes_left - 16'd1 : 16'd0;
                if (pes_left == 0) restart_hunt();
            end
        endcase
        if (emit) demux_out_q.push_back(out_r);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
        errs++;
    endtask

    task automatic check_result();
        t_result want;
        if (demux_out_q.size() == 0) begin
            $display("%0t: result transaction with none expected, actual kind %0d byte 0x%0h",
                     $time, i_result.kind, i_result.payload_byte);
            errs++;
        end else begin
            want = demux_out_q.pop_front();
            if (i_result.kind !== want.kind)
                note_mismatch("kind", want.kind, i_result.kind);
            if (i_result.payload_byte !== want.payload_byte)
                note_mismatch("payload_byte", want.payload_byte, i_result.payload_byte);
            if (i_result.frame_bytes !== want.frame_bytes)
                note_mismatch("frame_bytes", want.frame_bytes, i_result.frame_bytes);
            if (i_result.pts_ticks !== want.pts_ticks)
                note_mismatch("pts_ticks", want.pts_ticks, i_result.pts_ticks);
            if (i_result.stamp_ms !== want.stamp_ms)
                note_mismatch("stamp_ms", want.stamp_ms, i_result.stamp_ms);
            if (i_result.key_frame !== want.key_frame)
                note_mismatch("key_frame", want.key_frame, i_result.key_frame);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            video_id      = VIDEO_ID_RESET;
            start_window  = WINDOW_IDLE;
            parse_at      = PH_HUNT;
            skip_left     = '0;
            pes_left      = '0;
            hdr_left      = '0;
            ts_flags      = '0;
            pts_acc       = '0;
            frame_stamp   = '0;
            key_mark      = 1'b0;
            payload_tally = 0;
            in_video      = 1'b0;
            demux_out_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) check_result();
            if (i_cfg.valid && i_cfg.ready) video_id = i_cfg.video_stream_id;
            if (i_byte.valid && i_byte.ready) parse_stream_byte(i_byte.stream_byte);
        end
        o_fail_count <= errs;
        o_pending    <= demux_out_q.size();
    end

endmodule

[tb/sv/mpeg_ps_video_demux_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpeg_ps_video_demux_unit_tb
// Drives program stream bytes into the video demultiplexer: a directed set of
// pack, system, audio, unknown and video packets with their corner cases, then
// phases of random packet sequences under several video stream ids and idle
// patterns on both sides. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module mpeg_ps_video_demux_unit_tb;
    import mpsvd_pkg::*;

    localparam real CLK_PERIOD      = 8.0;
    localparam int  RESET_CYCLES    = 10;
    localparam int  CYCLE_LIMIT     = 200000;
    localparam int  BYTES_PER_PHASE = 200;
    localparam int  DRAIN_CYCLES    = 8;
    localparam int  NUM_PHASES      = 6;

    localparam logic [1:0] TS_NONE    = 2'b00;
    localparam logic [1:0] TS_INVALID = 2'b01;
    localparam logic [1:0] TS_PTS     = 2'b10;
    localparam logic [1:0] TS_PTS_DTS = 2'b11;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int          fail_count;
    int          pending_count;
    int          src_idle_pct = 36;
    int          snk_idle_pct = 66;
    int unsigned cycle_cnt    = 0;
    logic [7:0]  cur_vid      = VIDEO_ID_RESET;
    logic [7:0]  stream_q[$];
    logic [7:0]  phase_vid[NUM_PHASES] = '{VIDEO_ID_RESET, 8'h00, 8'hFF, SID_SYSTEM,
                                           SID_PACK, VIDEO_ID_RESET};

    mpsvd_byte_if   byte_ch();
    mpsvd_cfg_if    cfg_ch();
    mpsvd_result_if result_ch();

    mpeg_ps_video_demux_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    mpsvd_demux_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_cfg        (cfg_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [PTS_W-1:0] random_pts();
        return {1'($urandom), 32'($urandom)};
    endfunction

    task automatic put_start(input logic [7:0] sid);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h01);
        stream_q.push_back(sid);
    endtask

    task automatic put_pack(input logic [2:0] stuff);
        put_start(SID_PACK);
        repeat (PACK_FIXED_LEN) stream_q.push_back(8'($urandom));
        stream_q.push_back({5'($urandom), stuff});
        repeat (stuff) stream_q.push_back(8'($urandom));
    endtask

    task automatic put_plain(input logic [7:0] sid, input int len);
        put_start(sid);
        stream_q.push_back(8'(len >> 8));
        stream_q.push_back(8'(len));
        repeat (len) stream_q.push_back(8'($urandom));
    endtask

    // cut < 0 keeps the natural PES length, else the length field is cut
    task automatic put_video(input logic [7:0] sid, input logic [1:0] marker,
                             input logic [1:0] flags, input int hlen, input int npay,
                             input int cut, input logic [PTS_W-1:0] pts);
        logic [7:0] body[$];
        int         len;
        body.push_back({marker, 6'($urandom)});
        body.push_back({flags, 6'($urandom)});
        body.push_back(8'(hlen));
        for (int i = 0; i < hlen; i++) begin
            if (flags[1] && i < PTS_BYTES) begin
                case (t_pts_step'(i))
                    PTS_TOP:    body.push_back({4'($urandom), pts[32:30], 1'($urandom)});
                    PTS_MID_HI: body.push_back(pts[29:22]);
                    PTS_MID_LO: body.push_back({pts[21:15], 1'($urandom)});
                    PTS_LOW_HI: body.push_back(pts[14:7]);
                    default:    body.push_back({pts[6:0], 1'($urandom)});
                endcase
            end else begin
                body.push_back(8'($urandom));
            end
        end
        repeat (npay) body.push_back(8'($urandom));
        len = (cut >= 0) ? cut : body.size();
        put_start(sid);
        stream_q.push_back(8'(len >> 8));
        stream_q.push_back(8'(len));
        for (int i = 0; i < len; i++) stream_q.push_back(body[i]);
    endtask

    task automatic send_stream();
        bit taken;
        foreach (stream_q[k]) begin
            while ($urandom_range(0, 99) < src_idle_pct) begin
                byte_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            byte_ch.valid       <= 1'b1;
            byte_ch.stream_byte <= stream_q[k];
            do begin
                @(negedge i_clk);
                taken = byte_ch.ready;
                @(posedge i_clk);
            end while (!taken);
        end
        byte_ch.valid <= 1'b0;
        stream_q.delete();
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int         sel;
        int         hlen;
        int         npay;
        logic [1:0] flags;
        bit         cfg_ok;

        byte_ch.valid          = 1'b0;
        byte_ch.stream_byte    = 8'h00;
        cfg_ch.valid           = 1'b0;
        cfg_ch.video_stream_id = 8'h00;
        result_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                wait_idle();
                cur_vid = phase_vid[ph];
                cfg_ch.valid           <= 1'b1;
                cfg_ch.video_stream_id <= cur_vid;
                do begin
                    @(negedge i_clk);
                    cfg_ok = cfg_ch.ready;
                    @(posedge i_clk);
                end while (!cfg_ok);
                cfg_ch.valid <= 1'b0;
                src_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 66 : 0;
                snk_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 36 : 0;
            end else begin
                // empty frame, nothing to close
                put_pack(3'd0);
                put_plain(SID_SYSTEM, 0);
                put_video(cur_vid, PES_MARKER, TS_PTS, 5, 3, -1, '1);
                put_pack(3'd7);
                put_video(cur_vid, PES_MARKER, TS_PTS_DTS, 10, 2, -1, '0);
                put_video(cur_vid, PES_MARKER, TS_INVALID, 5, 1, -1, random_pts());
                put_video(cur_vid, PES_MARKER, TS_NONE, 0, 2, -1, random_pts());
                // header too short to hold the PTS
                put_video(cur_vid, PES_MARKER, TS_PTS, 3, 1, -1, random_pts());
                // length runs out inside the PTS, then inside the optional header
                put_video(cur_vid, PES_MARKER, TS_PTS, 5, 4, 6, random_pts());
                put_video(cur_vid, PES_MARKER, TS_PTS, 8, 2, 2, random_pts());
                put_video(cur_vid, PES_MARKER, TS_PTS, 5, 2, 0, random_pts());
                put_video(cur_vid, PES_MARKER ^ 2'b11, TS_PTS, 5, 3, -1, random_pts());
                put_video(cur_vid, PES_MARKER ^ 2'b01, TS_PTS, 5, 3, -1, random_pts());
                put_video(cur_vid, PES_MARKER ^ 2'b10, TS_PTS, 5, 3, -1, random_pts());
                put_plain(8'hC0, 4);
                put_plain(8'hB9, 3);
                put_plain(8'hBC, 0);
                put_plain(8'h00, 2);
                put_plain(8'hFF, 1);
                put_plain(SID_SYSTEM, 5);
                put_pack(3'd3);
                // key mark survives a pack header that closes nothing
                put_plain(SID_SYSTEM, 1);
                put_pack(3'd1);
                stream_q.push_back(8'h00);
                stream_q.push_back(8'h00);
                put_video(cur_vid, PES_MARKER, TS_PTS, 5, 2, -1, random_pts());
                put_pack(3'd0);
                send_stream();
            end

            if (ph == NUM_PHASES - 1)
                put_video(cur_vid, PES_MARKER, TS_PTS, 5, $urandom_range(256, 300), -1,
                          random_pts());
            while (stream_q.size() < BYTES_PER_PHASE) begin
                sel   = $urandom_range(0, 99);
                flags = ($urandom_range(0, 3) != 0) ? {1'b1, 1'($urandom)}
                                                    : {1'b0, 1'($urandom)};
                if (sel < 22) begin
                    put_pack(3'($urandom_range(0, 7)));
                end else if (sel < 28) begin
                    put_plain(SID_SYSTEM, $urandom_range(0, 12));
                end else if (sel < 35) begin
                    put_plain(8'($urandom), $urandom_range(0, 16));
                end else if (sel < 84) begin
                    hlen = ($urandom_range(0, 7) != 0) ? $urandom_range(5, 12)
                                                       : $urandom_range(0, 4);
                    if ($urandom_range(0, 19) == 0) hlen = $urandom_range(13, 40);
                    npay = $urandom_range(0, 16);
                    put_video(cur_vid, PES_MARKER, flags, hlen, npay, -1, random_pts());
                end else if (sel < 93) begin
                    hlen = $urandom_range(0, 8);
                    npay = $urandom_range(0, 10);
                    case ($urandom_range(0, 2))
                        0: put_video(cur_vid, PES_MARKER ^ 2'($urandom_range(1, 3)), flags,
                                     hlen, npay, -1, random_pts());
                        1: put_video(cur_vid, PES_MARKER, flags, hlen, npay,
                                     $urandom_range(0, 2 + hlen + npay), random_pts());
                        default: put_video(cur_vid, PES_MARKER, flags, hlen, npay, 0,
                                           random_pts());
                    endcase
                end else begin
                    repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
                end
            end
            send_stream();
        end

        wait_idle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
